// ===== design/rope_pkg.sv =====
// Shared types, constants and helper functions for the rotary position embedding block.
// Used by every module under design/ except rope_ram.
package rope_pkg;

    localparam int IDX_W      = 6;
    localparam int IDX_EXT_W  = 9;
    localparam int POS_W      = 12;
    localparam int DATA_W     = 16;
    localparam int FREQ_W     = 32;
    localparam int CS_W       = 18;
    localparam int ACC_W      = 36;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 32;
    localparam int DIGIT_W    = 4;

    localparam int HALF_DIM_DEF      = 64;
    localparam int MAX_POSITIONS_DEF = 4096;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 18'sd19898;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PHASE,
        ST_CORDIC,
        ST_ROTATE,
        ST_HOLD
    } rope_state_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] rope_atan(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Round half up by 2^15 and clip to 16 bits; bit 16 flags clipping
    function automatic logic [DATA_W:0] rope_round_clip(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic [DATA_W:0] r;
        t = (acc + 36'sd16384) >>> 15;
        if (t > 36'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (t < -36'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, t[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/rope_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rope_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rope_phase.sv =====
// Phase unit: position reduced modulo the position range one bit per cycle,
// then multiplied by the frequency one 4-bit digit per cycle. Uses rope_pkg.
module rope_phase #(
    parameter int MAX_POSITIONS = rope_pkg::MAX_POSITIONS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rope_pkg::POS_W-1:0]  pos,
    input  logic [rope_pkg::FREQ_W-1:0] freq,
    output logic                       done,
    output logic [rope_pkg::FREQ_W-1:0] phase
);
    import rope_pkg::*;

    localparam int MOD_STEPS = (MAX_POSITIONS < (1 << POS_W)) ? POS_W : 0;
    localparam int MUL_STEPS = POS_W / DIGIT_W;
    localparam int TOTAL     = MOD_STEPS + MUL_STEPS;
    localparam int SW        = $clog2(TOTAL);
    localparam int RW        = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) + 1 : 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [RW-1:0]     rem_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] acc_reg;
    logic [RW:0]       trial;
    logic [RW-1:0]     rem_next;
    logic              mod_active;
    logic              last_step;

    assign mod_active = step_reg < SW'(MOD_STEPS);
    assign last_step  = step_reg == SW'(TOTAL - 1);
    assign trial      = {rem_reg, pos_reg[POS_W-1]};
    assign rem_next   = (trial >= (RW+1)'(MAX_POSITIONS)) ?
                        RW'(trial - (RW+1)'(MAX_POSITIONS)) : RW'(trial);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && last_step) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            pos_reg  <= pos;
            rem_reg  <= '0;
            freq_reg <= freq;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + SW'(1);
            if (mod_active) begin
                rem_reg <= rem_next;
                // after the last division step the remainder becomes the multiplier
                if (step_reg == SW'(MOD_STEPS - 1)) begin
                    pos_reg <= POS_W'(rem_next);
                end else begin
                    pos_reg <= pos_reg << 1;
                end
            end else begin
                acc_reg <= FREQ_W'({acc_reg, {DIGIT_W{1'b0}}}
                           + freq_reg * pos_reg[POS_W-1 -: DIGIT_W]);
                pos_reg <= pos_reg << DIGIT_W;
            end
        end
    end

    assign done  = done_reg;
    assign phase = acc_reg;

endmodule

// ===== design/rope_cordic.sv =====
// Iterative CORDIC: one shift-add micro-rotation per cycle, then quadrant fold.
// Uses rope_pkg for the arctangent table and the gain constant.
module rope_cordic #(
    parameter int CORDIC_STEPS = rope_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [rope_pkg::FREQ_W-1:0]       phase,
    output logic                             done,
    output logic signed [rope_pkg::CS_W-1:0]  cos_out,
    output logic signed [rope_pkg::CS_W-1:0]  sin_out
);
    import rope_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            step_reg;
    logic signed [CS_W-1:0]   x_reg, y_reg;
    logic signed [FREQ_W-1:0] z_reg;
    logic [1:0]               quad_reg;
    logic signed [CS_W-1:0]   dx, dy;
    logic signed [FREQ_W-1:0] angle;
    logic                     last_step;

    assign last_step = step_reg == CW'(CORDIC_STEPS - 1);
    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign angle     = $signed(rope_atan(5'(step_reg)));

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && last_step) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({2'b00, phase[FREQ_W-3:0]});
            quad_reg <= phase[FREQ_W-1 -: 2];
        end else if (busy_reg) begin
            step_reg <= step_reg + CW'(1);
            if (!z_reg[FREQ_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - angle;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + angle;
            end
        end
    end

    always_comb begin
        case (quad_reg)
            2'd0: begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1: begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2: begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default: begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== design/rope_rotate.sv =====
// Final rotation: four products through one shared multiplier, accumulated,
// then rounded and clipped. Uses rope_pkg.
module rope_rotate (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [rope_pkg::DATA_W-1:0]  x1,
    input  logic signed [rope_pkg::DATA_W-1:0]  x2,
    input  logic signed [rope_pkg::CS_W-1:0]    cos_in,
    input  logic signed [rope_pkg::CS_W-1:0]    sin_in,
    output logic                               done,
    output logic signed [rope_pkg::DATA_W-1:0]  r1,
    output logic signed [rope_pkg::DATA_W-1:0]  r2,
    output logic                               sat
);
    import rope_pkg::*;

    localparam int LAST = 5;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [2:0]               step_reg;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [CS_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc1_reg, acc2_reg;
    logic [DATA_W:0]          c1, c2;
    logic signed [DATA_W-1:0] r1_reg, r2_reg;
    logic                     sat_reg;

    always_comb begin
        case (step_reg)
            3'd0: begin
                mul_a = x1;
                mul_b = cos_in;
            end
            3'd1: begin
                mul_a = x2;
                mul_b = sin_in;
            end
            3'd2: begin
                mul_a = x2;
                mul_b = cos_in;
            end
            default: begin
                mul_a = x1;
                mul_b = sin_in;
            end
        endcase
    end

    assign c1 = rope_round_clip(acc1_reg);
    assign c2 = rope_round_clip(acc2_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && step_reg == 3'(LAST)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 3'd1;
            prod_reg <= ACC_W'(mul_a * mul_b);
            case (step_reg)
                3'd1: acc1_reg <= prod_reg;
                3'd2: acc1_reg <= acc1_reg - prod_reg;
                3'd3: acc2_reg <= prod_reg;
                3'd4: acc2_reg <= acc2_reg + prod_reg;
                3'd5: begin
                    r1_reg  <= c1[DATA_W-1:0];
                    r2_reg  <= c2[DATA_W-1:0];
                    sat_reg <= c1[DATA_W] | c2[DATA_W];
                end
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign r1   = r1_reg;
    assign r2   = r2_reg;
    assign sat  = sat_reg;

endmodule

// ===== design/rotary_position_embedding.sv =====
// Rotary position embedding for one element pair per item. A load item
// (tuser 0) writes one frequency table entry, or nothing if its index is not
// below HALF_DIM; the input stays ready. A rotate item (tuser 1) reads its
// entry, forms the phase in a digit-serial multiplier (three 4-bit digits,
// plus twelve bit steps of position reduction when MAX_POSITIONS is below
// 4096), runs CORDIC_STEPS iterations of one shift-add CORDIC unit and four
// products on one shared multiplier, and holds the input side meanwhile.
// The result sits in an output register, so the next item is taken while it
// waits. Rotating with a never-written entry gives undefined results.
module rotary_position_embedding #(
    parameter int HALF_DIM      = rope_pkg::HALF_DIM_DEF,
    parameter int MAX_POSITIONS = rope_pkg::MAX_POSITIONS_DEF,
    parameter int CORDIC_STEPS  = rope_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pair_index[5:0], position[17:6], first_value[33:18], second_value[49:34],
    // frequency[81:50], zero fill
    input  logic [rope_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // first_rotated[15:0], second_rotated[31:16]
    output logic [rope_pkg::M_TDATA_W-1:0] m_tdata,
    // saturated
    output logic [0:0]                     m_tuser
);
    import rope_pkg::*;

    localparam int AW = (HALF_DIM > 1) ? $clog2(HALF_DIM) : 1;

    rope_state_t state_reg, state_next;

    logic [IDX_W-1:0]         in_idx;
    logic [POS_W-1:0]         in_pos;
    logic [FREQ_W-1:0]        in_freq;
    logic [IDX_EXT_W-1:0]     idx_ext;
    logic                     in_table;
    logic                     s_xfer, m_xfer;

    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] x1_reg, x2_reg;
    logic                     hit_reg;

    logic                     ram_we;
    logic [FREQ_W-1:0]        ram_rdata;

    logic                     phase_start, phase_done;
    logic [FREQ_W-1:0]        phase;
    logic                     cordic_start, cordic_done;
    logic signed [CS_W-1:0]   cos_v, sin_v;
    logic                     rot_start, rot_done;
    logic signed [DATA_W-1:0] r1, r2;
    logic                     sat;

    logic                     m_valid_reg, m_valid_next;
    logic                     out_load;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic                     m_sat_reg;

    assign in_idx   = s_tdata[5:0];
    assign in_pos   = s_tdata[17:6];
    assign in_freq  = s_tdata[81:50];
    assign idx_ext  = IDX_EXT_W'(in_idx);
    assign in_table = idx_ext < IDX_EXT_W'(HALF_DIM);

    assign s_tready = state_reg == ST_IDLE;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_valid_reg && m_tready;
    assign ram_we   = s_xfer && s_tuser[0] == OP_LOAD && in_table;

    rope_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (HALF_DIM)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (in_freq),
        .raddr (idx_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    rope_phase #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (phase_start),
        .pos     (pos_reg),
        .freq    (hit_reg ? ram_rdata : '0),
        .done    (phase_done),
        .phase   (phase)
    );

    rope_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .phase   (phase),
        .done    (cordic_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    rope_rotate u_rotate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_start),
        .x1      (x1_reg),
        .x2      (x2_reg),
        .cos_in  (cos_v),
        .sin_in  (sin_v),
        .done    (rot_done),
        .r1      (r1),
        .r2      (r2),
        .sat     (sat)
    );

    always_comb begin
        state_next   = state_reg;
        phase_start  = 1'b0;
        cordic_start = 1'b0;
        rot_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_tuser[0] == OP_ROTATE) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                phase_start = 1'b1;
                state_next  = ST_PHASE;
            end
            ST_PHASE: begin
                if (phase_done) begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (cordic_done) begin
                    rot_start  = 1'b1;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (rot_done) begin
                    if (!m_valid_reg || m_tready) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // result waits in the rotate unit until the output register frees
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_xfer) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pos_reg <= in_pos;
            x1_reg  <= $signed(s_tdata[33:18]);
            x2_reg  <= $signed(s_tdata[49:34]);
            hit_reg <= in_table;
        end
        if (out_load) begin
            m_data_reg <= {r2, r1};
            m_sat_reg  <= sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule

// ===== design/rope_checker.sv =====
// Port-level checks for rotary_position_embedding, attached by bind.
// Uses rope_pkg for widths and operation codes.
module rope_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rope_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import rope_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a rotate transfer occupies the block
    a_rotate_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_ROTATE |=> !s_tready)
        else $error("input ready right after rotate transfer");

    // a load leaves the input ready in the following cycle
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_LOAD |=> s_tready)
        else $error("input not ready after load transfer");

    // a new result comes only out of a busy period
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a rotate in flight");

    // a clip flag means at least one value sits at a limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000)
        else $error("saturation flag without a clipped value");

endmodule

bind rotary_position_embedding rope_checker u_rope_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
